// ===== hdl/sbn_pkg.sv =====
// shared types for the slice bound normalizer
`timescale 1ns / 1ps
package sbn_pkg;

  typedef struct packed {
    logic valid;
    logic nz;
  } sbn_ctl_t;

endpackage

// ===== hdl/sbn_resolve.sv =====
// bound resolution and span setup, two register stages
`timescale 1ns / 1ps
module sbn_resolve import sbn_pkg::*; #(
  parameter int W = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic [W-2:0]        len_i,
  input  logic signed [W-1:0] start_i,
  input  logic                start_abs_i,
  input  logic signed [W-1:0] stop_i,
  input  logic                stop_abs_i,
  input  logic signed [W-1:0] step_i,
  input  logic                step_abs_i,
  output sbn_ctl_t            ctl_o,
  output logic [W-1:0]        first_o,
  output logic [W-1:0]        stride_o,
  output logic [W-2:0]        span_o,
  output logic [W-1:0]        mag_o
);

  logic signed [W:0] lenx, first_d, last_d, first_q, last_q;
  logic signed [W-1:0] st_d, st_q;
  logic back, v0_q;
  logic signed [W:0] dif;
  logic pos, neg;
  sbn_ctl_t ctl_q;
  logic [W-1:0] first1_q, stride1_q, mag_q;
  logic [W-2:0] span_q;

  function automatic logic signed [W:0] resolve(
    input logic signed [W-1:0] b, input logic abs_b, input logic signed [W:0] len,
    input logic bk, input logic signed [W:0] dflt);
    logic signed [W:0] bx, w;
    bx = {b[W-1], b};
    w  = bx + len;
    if (abs_b) return dflt;
    if (bx < 0) return (w < 0) ? (bk ? -1 : 0) : w;
    if (bx >= len) return bk ? len - 1 : len;
    return bx;
  endfunction

  always_comb begin
    lenx    = {2'b00, len_i};
    st_d    = step_abs_i ? W'(1) : step_i;
    back    = st_d[W-1];
    first_d = resolve(start_i, start_abs_i, lenx, back, back ? lenx - 1 : '0);
    last_d  = resolve(stop_i, stop_abs_i, lenx, back, back ? -1 : lenx);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (en_i) begin
      v0_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      first_q <= first_d;
      last_q  <= last_d;
      st_q    <= st_d;
    end
  end

  // span minus one in the stride's direction
  always_comb begin
    pos = (st_q > 0) && (last_q > first_q);
    neg = (st_q < 0) && (last_q < first_q);
    dif = pos ? (last_q - first_q - 1) : (first_q - last_q - 1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (en_i) begin
      ctl_q.valid <= v0_q;
      ctl_q.nz    <= pos || neg;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      first1_q  <= first_q[W-1:0];
      stride1_q <= st_q;
      span_q    <= dif[W-2:0];
      mag_q     <= st_q[W-1] ? (~st_q + W'(1)) : st_q;
    end
  end

  assign ctl_o    = ctl_q;
  assign first_o  = first1_q;
  assign stride_o = stride1_q;
  assign span_o   = span_q;
  assign mag_o    = mag_q;

endmodule

// ===== hdl/sbn_div_stage.sv =====
// one restoring divide step with its pipeline register
`timescale 1ns / 1ps
module sbn_div_stage import sbn_pkg::*; #(
  parameter int W = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         en_i,
  input  sbn_ctl_t     ctl_i,
  input  logic [W-1:0] first_i,
  input  logic [W-1:0] stride_i,
  input  logic [W-2:0] dq_i,
  input  logic [W-1:0] rem_i,
  input  logic [W-1:0] mag_i,
  output sbn_ctl_t     ctl_o,
  output logic [W-1:0] first_o,
  output logic [W-1:0] stride_o,
  output logic [W-2:0] dq_o,
  output logic [W-1:0] rem_o,
  output logic [W-1:0] mag_o
);

  logic [W-1:0] trial, rem_d;
  logic [W-2:0] dq_d;
  logic         qbit;
  sbn_ctl_t     ctl_q;
  logic [W-1:0] first_q, stride_q, rem_q, mag_q;
  logic [W-2:0] dq_q;

  // dividend bits leave at the top, quotient bits enter at the bottom
  always_comb begin
    trial = {rem_i[W-2:0], dq_i[W-2]};
    qbit  = (trial >= mag_i);
    rem_d = qbit ? (trial - mag_i) : trial;
    dq_d  = {dq_i[W-3:0], qbit};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (en_i) begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      first_q  <= first_i;
      stride_q <= stride_i;
      dq_q     <= dq_d;
      rem_q    <= rem_d;
      mag_q    <= mag_i;
    end
  end

  assign ctl_o    = ctl_q;
  assign first_o  = first_q;
  assign stride_o = stride_q;
  assign dq_o     = dq_q;
  assign rem_o    = rem_q;
  assign mag_o    = mag_q;

endmodule

// ===== hdl/slice_bound_normalizer.sv =====
// top level of the slice bound normalizer
`timescale 1ns / 1ps
// resolves a python-style slice (length, optional start/stop/step) into first
// index, stride and element count. fully pipelined: while the output is not
// stalled one request is accepted every cycle, through INDEX_WIDTH+2 register
// stages (two stages of bound resolution, INDEX_WIDTH-1 restoring divide
// stages, one count/output stage); out_valid_o is driven from the last of
// them. the count needs ceil(span/|stride|), which sets the latency. when
// the output register is full and not taken the whole pipeline holds and
// in_ready_o drops; otherwise a new request enters each cycle
module slice_bound_normalizer import sbn_pkg::*; #(
  parameter int INDEX_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [INDEX_WIDTH-2:0]        seq_length_i,
  input  logic signed [INDEX_WIDTH-1:0] start_bound_i,
  input  logic                          start_absent_i,
  input  logic signed [INDEX_WIDTH-1:0] stop_bound_i,
  input  logic                          stop_absent_i,
  input  logic signed [INDEX_WIDTH-1:0] step_value_i,
  input  logic                          step_absent_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [INDEX_WIDTH-1:0] first_index_o,
  output logic signed [INDEX_WIDTH-1:0] stride_o,
  output logic [INDEX_WIDTH-2:0]        element_count_o
);

  localparam int W = INDEX_WIDTH;
  localparam int NDIV = W - 1;

  // pipeline moves as one when the output slot is free or being taken
  logic en;
  logic out_valid_q;
  logic [W-1:0] first_q, stride_q;
  logic [W-2:0] count_q;

  sbn_ctl_t     ctl  [NDIV+1];
  logic [W-1:0] fst  [NDIV+1];
  logic [W-1:0] strd [NDIV+1];
  logic [W-2:0] dq   [NDIV+1];
  logic [W-1:0] rem  [NDIV+1];
  logic [W-1:0] mag  [NDIV+1];

  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  sbn_resolve #(.W(W)) u_resolve (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (in_valid_i),
    .len_i      (seq_length_i),
    .start_i    (start_bound_i),
    .start_abs_i(start_absent_i),
    .stop_i     (stop_bound_i),
    .stop_abs_i (stop_absent_i),
    .step_i     (step_value_i),
    .step_abs_i (step_absent_i),
    .ctl_o      (ctl[0]),
    .first_o    (fst[0]),
    .stride_o   (strd[0]),
    .span_o     (dq[0]),
    .mag_o      (mag[0])
  );

  // remainder starts at zero, dividend sits in the shift register
  assign rem[0] = '0;

  for (genvar k = 0; k < NDIV; k++) begin : g_div
    sbn_div_stage #(.W(W)) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .ctl_i   (ctl[k]),
      .first_i (fst[k]),
      .stride_i(strd[k]),
      .dq_i    (dq[k]),
      .rem_i   (rem[k]),
      .mag_i   (mag[k]),
      .ctl_o   (ctl[k+1]),
      .first_o (fst[k+1]),
      .stride_o(strd[k+1]),
      .dq_o    (dq[k+1]),
      .rem_o   (rem[k+1]),
      .mag_o   (mag[k+1])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= ctl[NDIV].valid;
    end
  end

  // count is quotient of (span-1) plus one, zero when the stride is zero or the span is empty in its direction
  always_ff @(posedge clk_i) begin
    if (en) begin
      first_q  <= fst[NDIV];
      stride_q <= strd[NDIV];
      count_q  <= ctl[NDIV].nz ? (dq[NDIV] + (W-1)'(1)) : '0;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign first_index_o   = first_q;
  assign stride_o        = stride_q;
  assign element_count_o = count_q;

  logic unused_rem;
  assign unused_rem = ^{rem[NDIV], mag[NDIV]};

endmodule

// ===== bench/tb_slice_bound_normalizer.sv =====
// testbench for the slice bound normalizer: directed table plus random slices
`timescale 1ns / 1ps
module tb_slice_bound_normalizer;
  localparam int W = 32;
  localparam int LAT = W + 2;
  localparam int RANDOM_ITEMS = 1280;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [W-2:0]        len;
    logic signed [W-1:0] start_b;
    logic                start_abs;
    logic signed [W-1:0] stop_b;
    logic                stop_abs;
    logic signed [W-1:0] step_v;
    logic                step_abs;
  } slice_req_t;

  typedef struct packed {
    logic signed [W-1:0] first;
    logic signed [W-1:0] stride;
    logic [W-2:0]        count;
  } slice_res_t;

  // one row of the directed table; has_res marks a result typed in by hand
  typedef struct packed {
    slice_req_t req;
    logic       has_res;
    slice_res_t res;
  } slice_row_t;

  logic clk_i, rst_ni;
  logic in_valid_i, in_ready_o, out_valid_o, out_ready_i;
  logic [W-2:0] seq_length_i, element_count_o;
  logic signed [W-1:0] start_bound_i, stop_bound_i, step_value_i;
  logic start_absent_i, stop_absent_i, step_absent_i;
  logic signed [W-1:0] first_index_o, stride_o;

  slice_bound_normalizer #(.INDEX_WIDTH(W)) uut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o,
    .seq_length_i, .start_bound_i, .start_absent_i, .stop_bound_i,
    .stop_absent_i, .step_value_i, .step_absent_i,
    .out_valid_o, .out_ready_i, .first_index_o, .stride_o, .element_count_o
  );

  slice_res_t expected_slices[$];
  int errors = 0;
  longint cycle = 0;
  int send_idle_pct = 19;
  int recv_idle_pct = 58;
  bit recv_hold = 0;

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle <= cycle + 1;
    if (cycle > CYCLE_LIMIT) begin
      $display("tb_slice_bound_normalizer failed");
      $finish;
    end
  end

  // python-style bound resolution in 64-bit signed arithmetic
  function automatic longint resolve_slice_bound(longint b, bit absent, longint len,
                                                 bit backward, longint dflt);
    longint w;
    if (absent) return dflt;
    if (b < 0) begin
      w = b + len;
      if (w < 0) return backward ? -1 : 0;
      return w;
    end
    if (b >= len) return backward ? len - 1 : len;
    return b;
  endfunction

  function automatic slice_res_t normalize_slice(slice_req_t r);
    longint len, st, first, last, span, mag;
    bit back;
    slice_res_t res;
    len = longint'({1'b0, r.len});
    st = r.step_abs ? 64'sd1 : longint'(r.step_v);
    back = st < 0;
    first = resolve_slice_bound(longint'(r.start_b), r.start_abs, len, back,
                                back ? len - 1 : 0);
    last = resolve_slice_bound(longint'(r.stop_b), r.stop_abs, len, back,
                               back ? -1 : len);
    res.count = '0;
    if (st > 0 && last > first) begin
      span = last - first - 1;
      res.count = (W-1)'(span / st + 1);
    end else if (st < 0 && last < first) begin
      span = first - last - 1;
      mag = -st;
      res.count = (W-1)'(span / mag + 1);
    end
    res.first = first[W-1:0];
    res.stride = st[W-1:0];
    return res;
  endfunction

  // receiver: random stalls, plus a long hold-off when asked
  always @(posedge clk_i) begin
    if (!rst_ni) out_ready_i <= 1'b0;
    else out_ready_i <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
  end

  // checker: compare each accepted result with the oldest expectation
  always @(posedge clk_i) begin
    slice_res_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_slices.size() == 0) begin
        $display("%0t: unexpected result first=%0d stride=%0d count=%0d",
                 $time, first_index_o, stride_o, element_count_o);
        errors++;
      end else begin
        want = expected_slices.pop_front();
        if (first_index_o !== want.first) begin
          $display("%0t: first_index expected %0d actual %0d", $time, want.first,
                   first_index_o);
          errors++;
        end
        if (stride_o !== want.stride) begin
          $display("%0t: stride expected %0d actual %0d", $time, want.stride, stride_o);
          errors++;
        end
        if (element_count_o !== want.count) begin
          $display("%0t: element_count expected %0d actual %0d", $time, want.count,
                   element_count_o);
          errors++;
        end
      end
    end
  end

  // offer one request and hold it until accepted
  task automatic send_slice(slice_req_t r, slice_res_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    {seq_length_i, start_bound_i, start_absent_i, stop_bound_i, stop_absent_i,
     step_value_i, step_absent_i} <= r;
    do @(posedge clk_i); while (!in_ready_o);
    expected_slices.push_back(want);
  endtask

  function automatic logic signed [W-1:0] pick_bound(logic [W-2:0] len);
    case ($urandom_range(5))
      0: return $urandom();
      1: return W'(len) - W'($urandom_range(3));
      2: return -W'(len) + W'($urandom_range(3)) - 1;
      3: return $signed(W'($urandom_range(40))) - 20;
      4: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
      default: return W'($urandom_range(len));
    endcase
  endfunction

  function automatic slice_req_t random_slice();
    slice_req_t r;
    case ($urandom_range(3))
      0: r.len = (W-1)'($urandom());
      1: r.len = '1 - (W-1)'($urandom_range(3));
      default: r.len = (W-1)'($urandom_range(100));
    endcase
    r.start_b = pick_bound(r.len);
    r.stop_b = pick_bound(r.len);
    case ($urandom_range(5))
      0: r.step_v = $urandom();
      1: r.step_v = $urandom_range(1) ? 32'sh80000000 : 32'sh7fffffff;
      2: r.step_v = 0;
      default: r.step_v = $signed(W'($urandom_range(16))) - 8;
    endcase
    r.start_abs = $urandom_range(3) == 0;
    r.stop_abs = $urandom_range(3) == 0;
    r.step_abs = $urandom_range(3) == 0;
    return r;
  endfunction

  // directed rows: len, start, sabs, stop, eabs, step, stabs | typed result
  slice_row_t slice_table[] = '{
    '{'{31'd10, 32'sd0, 1'b1, 32'sd0, 1'b1, 32'sd0, 1'b1}, 1'b1,
      '{32'sd0, 32'sd1, 31'd10}},
    '{'{31'd10, 32'sd0, 1'b1, 32'sd0, 1'b1, -32'sd1, 1'b0}, 1'b1,
      '{32'sd9, -32'sd1, 31'd10}},
    '{'{31'd10, 32'sd2, 1'b0, 32'sd8, 1'b0, 32'sd0, 1'b0}, 1'b1,
      '{32'sd2, 32'sd0, 31'd0}},
    '{'{31'd0, 32'sd0, 1'b1, 32'sd0, 1'b1, -32'sd1, 1'b0}, 1'b1,
      '{-32'sd1, -32'sd1, 31'd0}},
    '{'{31'd0, 32'sd5, 1'b0, -32'sd5, 1'b0, 32'sd1, 1'b0}, 1'b1,
      '{32'sd0, 32'sd1, 31'd0}},
    '{'{31'd10, -32'sd100, 1'b0, -32'sd100, 1'b0, -32'sd1, 1'b0}, 1'b0, '0},
    '{'{31'd10, 32'sd100, 1'b0, 32'sd100, 1'b0, -32'sd2, 1'b0}, 1'b0, '0},
    '{'{31'd10, -32'sd3, 1'b0, -32'sd1, 1'b0, 32'sd1, 1'b0}, 1'b0, '0},
    '{'{31'd10, 32'sd8, 1'b0, 32'sd2, 1'b0, 32'sd3, 1'b0}, 1'b0, '0},
    '{'{31'h7fffffff, 32'sh80000000, 1'b0, 32'sh7fffffff, 1'b0, 32'sd1, 1'b0},
      1'b0, '0},
    '{'{31'h7fffffff, 32'sh7fffffff, 1'b0, 32'sh80000000, 1'b0, 32'sh80000000,
       1'b0}, 1'b0, '0},
    '{'{31'h7fffffff, 32'sd0, 1'b1, 32'sd0, 1'b1, 32'sh7fffffff, 1'b0}, 1'b0, '0},
    '{'{31'h7fffffff, 32'sd0, 1'b1, 32'sd0, 1'b1, -32'sd1, 1'b0}, 1'b0, '0},
    '{'{31'h55555555, 32'sh55555555, 1'b0, 32'shaaaaaaaa, 1'b0, 32'sh55555555,
       1'b1}, 1'b0, '0},
    '{'{31'h2aaaaaaa, 32'shaaaaaaaa, 1'b1, 32'sh55555555, 1'b1, 32'shaaaaaaaa,
       1'b0}, 1'b0, '0},
    '{'{31'd7, 32'sd1, 1'b0, 32'sd6, 1'b0, 32'sd2, 1'b0}, 1'b0, '0},
    '{'{31'd7, 32'sd6, 1'b0, 32'sd0, 1'b0, -32'sd2, 1'b0}, 1'b0, '0}
  };

  initial begin
    slice_req_t r;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    {seq_length_i, start_bound_i, start_absent_i, stop_bound_i, stop_absent_i,
     step_value_i, step_absent_i} = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (slice_table[i])
      send_slice(slice_table[i].req, slice_table[i].has_res ? slice_table[i].res
                                                            : normalize_slice(slice_table[i].req));

    // receiver holds off for a long stretch while requests keep coming
    fork
      begin
        recv_hold = 1;
        repeat (3 * LAT) @(posedge clk_i);
        recv_hold = 0;
      end
      for (int i = 0; i < 3 * LAT; i++) begin
        r = random_slice();
        send_slice(r, normalize_slice(r));
      end
    join

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS / 3) begin
        send_idle_pct = 58;
        recv_idle_pct = 19;
      end
      if (i == 2 * RANDOM_ITEMS / 3) begin
        // sender pauses until the pipeline drains, then no idling at all
        in_valid_i <= 1'b0;
        while (expected_slices.size() != 0) @(posedge clk_i);
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      r = random_slice();
      send_slice(r, normalize_slice(r));
    end
    in_valid_i <= 1'b0;

    while (expected_slices.size() != 0) @(posedge clk_i);
    repeat (LAT + 4) @(posedge clk_i);
    if (errors == 0)
      $display("tb_slice_bound_normalizer passed");
    else
      $display("tb_slice_bound_normalizer failed");
    $finish;
  end
endmodule

// ===== filelist.f =====
hdl/sbn_pkg.sv
hdl/sbn_resolve.sv
hdl/sbn_div_stage.sv
hdl/slice_bound_normalizer.sv
bench/tb_slice_bound_normalizer.sv
